>>> hw/rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the sprite screen projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package ssp_pkg;

  localparam int FRONT_STAGES = 6;
  localparam int QUO_W        = 32;
  localparam int DIV_STAGES   = QUO_W + 1;
  localparam int BACK_STAGES  = 2;
  localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  localparam int NCOL_W   = 64;
  localparam int NSIZE_W  = 49;
  localparam int NDEPTH_W = 67;
  localparam int DNY_W    = 51;
  localparam int DDET_W   = 36;

  localparam logic [2:0] REG_CAM_X         = 3'd0;
  localparam logic [2:0] REG_CAM_Y         = 3'd1;
  localparam logic [2:0] REG_DIR_X         = 3'd2;
  localparam logic [2:0] REG_DIR_Y         = 3'd3;
  localparam logic [2:0] REG_PLANE_X       = 3'd4;
  localparam logic [2:0] REG_PLANE_Y       = 3'd5;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd7;

  typedef struct packed {
    logic [31:0] cam_x;
    logic [31:0] cam_y;
    logic [17:0] dir_x;
    logic [17:0] dir_y;
    logic [17:0] plane_x;
    logic [17:0] plane_y;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic neg_col;
    logic neg_depth;
    logic fault;
  } flags_t;

endpackage
`default_nettype wire

>>> hw/rtl/ssp_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// ssp_pipe_ctrl
// Valid bits of all pipeline stages and per-stage load enables; a stage
// loads when it is empty or the stage after it loads.
// ----------------------------------------------------------------------------
`default_nettype none
module ssp_pipe_ctrl import ssp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIPE_STAGES-1:0] load
);

  logic [PIPE_STAGES-1:0] valid;
  logic [PIPE_STAGES-1:0] valid_next;

  assign load[PIPE_STAGES-1] = !valid[PIPE_STAGES-1] || out_ready;

  for (genvar i = 0; i < PIPE_STAGES - 1; i++) begin : g_load
    assign load[i] = !valid[i] || load[i+1];
  end

  assign valid_next = (load & {valid[PIPE_STAGES-2:0], in_valid}) | (~load & valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_ready  = load[0];
  assign out_valid = valid[PIPE_STAGES-1];

endmodule
`default_nettype wire

>>> hw/rtl/ssp_front.sv
// ----------------------------------------------------------------------------
// ssp_front
// Camera offset, transform products, determinant and divider operands.
// ----------------------------------------------------------------------------
`default_nettype none
module ssp_front import ssp_pkg::*; (
  input  logic                    clk,
  input  cfg_t                    cfg,
  input  logic [FRONT_STAGES-1:0] load,
  input  logic signed [31:0]      sprite_x,
  input  logic signed [31:0]      sprite_y,
  output logic [NCOL_W-1:0]       num_col,
  output logic [NSIZE_W-1:0]      num_size,
  output logic [NDEPTH_W-1:0]     num_depth,
  output logic [DNY_W-1:0]        den_ny,
  output logic [DDET_W-1:0]       den_det,
  output flags_t                  flags
);

  logic signed [17:0] dir_x, dir_y, plane_x, plane_y;
  logic signed [32:0] sx, sy;
  logic signed [35:0] p1, p2;
  logic signed [50:0] m_a, m_b, m_c, m_d;
  logic signed [36:0] det1, det2, det3, det4;
  logic signed [51:0] nx, ny, ny3, ny4;
  logic signed [52:0] s3;
  logic signed [49:0] hd3, hd4;
  logic signed [64:0] num4;
  logic               fault3, fault4;

  assign dir_x   = cfg.dir_x;
  assign dir_y   = cfg.dir_y;
  assign plane_x = cfg.plane_x;
  assign plane_y = cfg.plane_y;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      sx <= {sprite_x[31], sprite_x} - {cfg.cam_x[31], cfg.cam_x};
      sy <= {sprite_y[31], sprite_y} - {cfg.cam_y[31], cfg.cam_y};
      p1 <= plane_x * dir_y;
      p2 <= dir_x * plane_y;
    end
    if (load[1]) begin
      m_a  <= dir_x * sy;
      m_b  <= dir_y * sx;
      m_c  <= plane_x * sy;
      m_d  <= plane_y * sx;
      det1 <= p1 - p2;
    end
    if (load[2]) begin
      nx   <= m_a - m_b;
      ny   <= m_c - m_d;
      det2 <= det1;
    end
    if (load[3]) begin
      s3     <= nx + ny;
      hd3    <= $signed({1'b0, cfg.screen_height}) * det2;
      ny3    <= ny;
      det3   <= det2;
      fault3 <= (det2 == '0) || (ny == '0);
    end
    if (load[4]) begin
      num4   <= $signed({1'b0, cfg.screen_width[11:1]}) * s3;
      hd4    <= hd3;
      ny4    <= ny3;
      det4   <= det3;
      fault4 <= fault3;
    end
    if (load[5]) begin
      num_col   <= num4[64] ? NCOL_W'(-num4) : NCOL_W'(num4);
      num_size  <= hd4[49] ? NSIZE_W'(-hd4) : NSIZE_W'(hd4);
      num_depth <= {(ny4[51] ? DNY_W'(-ny4) : DNY_W'(ny4)), 16'd0};
      den_ny    <= ny4[51] ? DNY_W'(-ny4) : DNY_W'(ny4);
      den_det   <= det4[36] ? DDET_W'(-det4) : DDET_W'(det4);
      flags     <= '{neg_col: num4[64] ^ ny4[51], neg_depth: ny4[51] ^ det4[36],
                     fault: fault4};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ssp_divider.sv
// ----------------------------------------------------------------------------
// ssp_divider
// Pipelined restoring divider, one quotient bit per stage, with a flag for
// quotients that do not fit the quotient width.
// ----------------------------------------------------------------------------
`default_nettype none
module ssp_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 51,
  parameter int QUO_W = 32
) (
  input  logic             clk,
  input  logic [QUO_W:0]   load,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             sat
);

  localparam int RW = (NUM_W > DEN_W ? NUM_W : DEN_W) + QUO_W;

  logic [NUM_W-1:0] rem [QUO_W];
  logic [DEN_W-1:0] dv  [QUO_W];
  logic [QUO_W-1:0] q   [QUO_W+1];
  logic             sv  [QUO_W+1];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      rem[0] <= num;
      dv[0]  <= den;
      q[0]   <= '0;
      sv[0]  <= RW'(num) >= (RW'(den) << QUO_W);
    end
  end

  for (genvar j = 1; j <= QUO_W; j++) begin : g_step
    localparam int K = QUO_W - j;
    logic [RW-1:0] trial;
    logic [RW-1:0] diff;
    logic          ge;

    assign trial = RW'(dv[j-1]) << K;
    assign ge    = RW'(rem[j-1]) >= trial;
    assign diff  = RW'(rem[j-1]) - trial;

    always_ff @(posedge clk) begin
      if (load[j]) begin
        q[j]  <= q[j-1] | (QUO_W'(ge) << K);
        sv[j] <= sv[j-1];
      end
    end

    if (j < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (load[j]) begin
          rem[j] <= ge ? diff[NUM_W-1:0] : rem[j-1];
          dv[j]  <= dv[j-1];
        end
      end
    end
  end

  assign quo = q[QUO_W];
  assign sat = sv[QUO_W];

endmodule
`default_nettype wire

>>> hw/rtl/ssp_back.sv
// ----------------------------------------------------------------------------
// ssp_back
// Quotient saturation and signs, then draw bounds clamped to the screen.
// ----------------------------------------------------------------------------
`default_nettype none
module ssp_back import ssp_pkg::*; (
  input  logic                   clk,
  input  cfg_t                   cfg,
  input  logic [BACK_STAGES-1:0] load,
  input  logic [QUO_W-1:0]       quo_col,
  input  logic                   sat_col,
  input  logic [QUO_W-1:0]       quo_size,
  input  logic                   sat_size,
  input  logic [QUO_W-1:0]       quo_depth,
  input  logic                   sat_depth,
  input  flags_t                 flags,
  output logic signed [20:0]     screen_column,
  output logic [15:0]            sprite_size,
  output logic [11:0]            top_row,
  output logic [11:0]            bottom_row,
  output logic [19:0]            left_column,
  output logic signed [20:0]     right_column,
  output logic signed [31:0]     depth,
  output logic                   divide_fault
);

  logic [20:0] max_col, qc;
  logic [32:0] max_depth;
  logic [31:0] qd;
  logic [20:0] col_a;
  logic [15:0] size_a;
  logic [31:0] depth_a;
  logic        fault_a;

  logic [14:0] half;
  logic [10:0] sh2;
  logic [16:0] top_s, bot_s;
  logic [22:0] left_s, right_s, sw1;
  logic [11:0] top_v, bot_v;
  logic [19:0] left_v;
  logic [20:0] right_v;

  always_comb begin
    max_col   = flags.neg_col ? 21'd1048576 : 21'd1048575;
    qc        = (sat_col || quo_col > {11'd0, max_col}) ? max_col : quo_col[20:0];
    max_depth = flags.neg_depth ? 33'd2147483648 : 33'd2147483647;
    qd        = (sat_depth || {1'b0, quo_depth} > max_depth) ? max_depth[31:0] : quo_depth;
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      col_a   <= flags.neg_col ? -qc : qc;
      size_a  <= (sat_size || quo_size > 32'd65535) ? 16'hFFFF : quo_size[15:0];
      depth_a <= flags.neg_depth ? -qd : qd;
      fault_a <= flags.fault;
    end
  end

  always_comb begin
    half    = size_a[15:1];
    sh2     = cfg.screen_height[11:1];
    top_s   = {6'd0, sh2} - {2'd0, half};
    bot_s   = {6'd0, sh2} + {2'd0, half};
    left_s  = {{2{col_a[20]}}, col_a} - {8'd0, half};
    right_s = {{2{col_a[20]}}, col_a} + {8'd0, half};
    sw1     = {11'd0, cfg.screen_width} - 23'd1;
    top_v   = top_s[16] ? 12'd0 : top_s[11:0];
    bot_v   = (bot_s >= {5'd0, cfg.screen_height}) ? cfg.screen_height - 12'd1
                                                    : bot_s[11:0];
    left_v  = left_s[22] ? 20'd0 : left_s[19:0];
    right_v = ($signed(right_s) >= $signed(sw1)) ? sw1[20:0] : right_s[20:0];
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      screen_column <= fault_a ? '0 : col_a;
      sprite_size   <= fault_a ? '0 : size_a;
      top_row       <= fault_a ? '0 : top_v;
      bottom_row    <= fault_a ? '0 : bot_v;
      left_column   <= fault_a ? '0 : left_v;
      right_column  <= fault_a ? '0 : right_v;
      depth         <= fault_a ? '0 : depth_a;
      divide_fault  <= fault_a;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sprite_screen_projection_unit.sv
// throughput: one sprite per cycle while out_ready is high, through the 33-stage quotient pipelines
// three dividers run in lockstep, one quotient bit per stage
// reset: synchronous, clears all stage valid bits and loads register defaults
// ----------------------------------------------------------------------------
// sprite_screen_projection_unit
// Projects a sprite map position through the configured camera into screen
// column, size, draw bounds and depth.
// ----------------------------------------------------------------------------
`default_nettype none
module sprite_screen_projection_unit import ssp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] sprite_x,
  input  logic signed [31:0] sprite_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [20:0] screen_column,
  output logic [15:0]        sprite_size,
  output logic [11:0]        top_row,
  output logic [11:0]        bottom_row,
  output logic [19:0]        left_column,
  output logic signed [20:0] right_column,
  output logic signed [31:0] depth,
  output logic               divide_fault
);

  cfg_t                   cfg;
  logic [PIPE_STAGES-1:0] load;
  logic [NCOL_W-1:0]      num_col;
  logic [NSIZE_W-1:0]     num_size;
  logic [NDEPTH_W-1:0]    num_depth;
  logic [DNY_W-1:0]       den_ny;
  logic [DDET_W-1:0]      den_det;
  flags_t                 flags_f;
  flags_t                 tag [DIV_STAGES];
  logic [QUO_W-1:0]       quo_col, quo_size, quo_depth;
  logic                   sat_col, sat_size, sat_depth;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_x         <= 32'd0;
      cfg.cam_y         <= 32'd0;
      cfg.dir_x         <= -18'sd65536;
      cfg.dir_y         <= 18'd0;
      cfg.plane_x       <= 18'd0;
      cfg.plane_y       <= 18'sd43254;
      cfg.screen_width  <= 12'd640;
      cfg.screen_height <= 12'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAM_X:         cfg.cam_x         <= cfg_data;
        REG_CAM_Y:         cfg.cam_y         <= cfg_data;
        REG_DIR_X:         cfg.dir_x         <= cfg_data[17:0];
        REG_DIR_Y:         cfg.dir_y         <= cfg_data[17:0];
        REG_PLANE_X:       cfg.plane_x       <= cfg_data[17:0];
        REG_PLANE_Y:       cfg.plane_y       <= cfg_data[17:0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  ssp_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .load      (load)
  );

  ssp_front u_front (
    .clk       (clk),
    .cfg       (cfg),
    .load      (load[FRONT_STAGES-1:0]),
    .sprite_x  (sprite_x),
    .sprite_y  (sprite_y),
    .num_col   (num_col),
    .num_size  (num_size),
    .num_depth (num_depth),
    .den_ny    (den_ny),
    .den_det   (den_det),
    .flags     (flags_f)
  );

  ssp_divider #(.NUM_W(NCOL_W), .DEN_W(DNY_W), .QUO_W(QUO_W)) u_div_col (
    .clk  (clk),
    .load (load[FRONT_STAGES +: DIV_STAGES]),
    .num  (num_col),
    .den  (den_ny),
    .quo  (quo_col),
    .sat  (sat_col)
  );

  ssp_divider #(.NUM_W(NSIZE_W), .DEN_W(DNY_W), .QUO_W(QUO_W)) u_div_size (
    .clk  (clk),
    .load (load[FRONT_STAGES +: DIV_STAGES]),
    .num  (num_size),
    .den  (den_ny),
    .quo  (quo_size),
    .sat  (sat_size)
  );

  ssp_divider #(.NUM_W(NDEPTH_W), .DEN_W(DDET_W), .QUO_W(QUO_W)) u_div_depth (
    .clk  (clk),
    .load (load[FRONT_STAGES +: DIV_STAGES]),
    .num  (num_depth),
    .den  (den_det),
    .quo  (quo_depth),
    .sat  (sat_depth)
  );

  // sign and fault flags follow the divider stages
  always_ff @(posedge clk) begin
    if (load[FRONT_STAGES]) begin
      tag[0] <= flags_f;
    end
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_tag
    always_ff @(posedge clk) begin
      if (load[FRONT_STAGES+j]) begin
        tag[j] <= tag[j-1];
      end
    end
  end

  ssp_back u_back (
    .clk           (clk),
    .cfg           (cfg),
    .load          (load[PIPE_STAGES-1 -: BACK_STAGES]),
    .quo_col       (quo_col),
    .sat_col       (sat_col),
    .quo_size      (quo_size),
    .sat_size      (sat_size),
    .quo_depth     (quo_depth),
    .sat_depth     (sat_depth),
    .flags         (tag[DIV_STAGES-1]),
    .screen_column (screen_column),
    .sprite_size   (sprite_size),
    .top_row       (top_row),
    .bottom_row    (bottom_row),
    .left_column   (left_column),
    .right_column  (right_column),
    .depth         (depth),
    .divide_fault  (divide_fault)
  );

`ifndef SYNTH
  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_fault) |->
      (screen_column == '0 && sprite_size == '0 && depth == '0 && left_column == '0))
    else $error("fault beat carries nonzero fields");

  a_rows_ordered: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !divide_fault) |-> (top_row <= bottom_row))
    else $error("top row below bottom row");
`endif

endmodule
`default_nettype wire
